// ----- hdl/ftlu_pkg.sv -----
package ftlu_pkg;

	localparam int SET_COUNT = 256;
	localparam int TAG_BITS  = 20;
	localparam int WAYS      = 4;
	localparam int IDX_W     = $clog2(SET_COUNT);

	localparam logic [WAYS-1:0] WAY_BIT [WAYS] = '{4'b0001, 4'b0010, 4'b0100, 4'b1000};

	typedef struct packed {
		logic                chip_enable;
		logic                write_enable;
		logic                output_enable;
		logic [7:0]          set_index;
		logic [TAG_BITS-1:0] tag_in;
		logic [1:0]          victim_way;
	} req_t;

	typedef struct packed {
		logic            hit;
		logic [WAYS-1:0] way_match;
		logic [WAYS-1:0] snoop_ways;
		logic            evict;
	} rsp_t;

	// tag store write port: per-way enables share one index and tag
	typedef struct packed {
		logic [WAYS-1:0]     way_we;
		logic [IDX_W-1:0]    idx;
		logic [TAG_BITS-1:0] tag;
	} tag_wr_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOK
	} state_t;

endpackage

// ----- hdl/ftlu_tag_ram.sv -----
module ftlu_tag_ram (
	input  logic                                             clk,
	input  logic                                             arst_n,
	input  logic                                             rd_en,
	input  logic [ftlu_pkg::IDX_W-1:0]                       rd_idx,
	input  ftlu_pkg::tag_wr_t                                wr,
	output logic                                             clearing,
	output logic [ftlu_pkg::WAYS-1:0][ftlu_pkg::TAG_BITS-1:0] rd_tags
);
	import ftlu_pkg::*;

	// one row holds the four ways of a set; per-way write enables
	logic [WAYS-1:0][TAG_BITS-1:0] mem [SET_COUNT];
	logic [WAYS-1:0][TAG_BITS-1:0] rd_data_q;
	logic                          clr_active_q;
	logic [IDX_W-1:0]              clr_idx_q;

	// zero every set once after reset, one set per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_idx_q    <= '0;
		end else if (clr_active_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == IDX_W'(SET_COUNT - 1)) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			mem[clr_idx_q] <= '0;
		end else begin
			for (int w = 0; w < WAYS; w++) begin
				if (wr.way_we[w]) begin
					mem[wr.idx][w] <= wr.tag;
				end
			end
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_idx];
		end
	end

	assign clearing = clr_active_q;
	assign rd_tags  = rd_data_q;

endmodule

// ----- hdl/four_way_tag_lookup_update_core.sv -----
// Four-way set-associative tag array with one-deep write forwarding.
// Request side: a transaction is taken on a rising edge with start high and
//   busy low; req carries chip/write/output enables, set index, tag and the
//   victim way for write misses.
// Result side: done pulses for exactly one cycle with result (hit, way
//   match mask, snoop mask, evict). The receiver cannot stall; every taken
//   request gives one result, idle bus cycles give an all-zero one.
// The result appears in the cycle after acceptance.
// No new transaction is taken before the current one is compared, due to
//   the synchronous tag RAM read (address cycle, then compare cycle);
//   busy is high in the compare cycle.
// The user writes the tag mask register (tag_mask_we/tag_mask_wdata) only
//   while idle; not enforced by the block. It masks compare and store tags.
// A write is held as pending and committed to the RAM in the compare cycle
//   of the next transaction; a lookup to the pending set is answered from
//   the pending way mask (index compare only) and reports it as snoop.
// Reset: no pending write, tag mask all ones. A clearing pass then zeroes
//   the tag RAM one set per cycle; busy is high until the pass ends.
module four_way_tag_lookup_update_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  ftlu_pkg::req_t                req,
	input  logic                          tag_mask_we,
	input  logic [ftlu_pkg::TAG_BITS-1:0] tag_mask_wdata,
	output logic                          done,
	output ftlu_pkg::rsp_t                result
);
	import ftlu_pkg::*;

	state_t state_q, state_d;

	logic [TAG_BITS-1:0] tag_mask_q;

	// captured request
	logic                lookup_s1;
	logic                wr_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [TAG_BITS-1:0] tag_s1;
	logic [1:0]          victim_s1;

	// pending write, committed in the next compare cycle
	logic                pend_valid_q;
	logic [IDX_W-1:0]    pend_idx_q;
	logic [TAG_BITS-1:0] pend_tag_q;
	logic [WAYS-1:0]     pend_way_q;

	logic                              accept;
	logic                              ram_clearing;
	logic [WAYS-1:0][TAG_BITS-1:0]     rd_tags;
	tag_wr_t                           ram_wr;
	logic                              fwd;
	logic [WAYS-1:0]                   cmp_match;
	logic                              hit;
	logic [WAYS-1:0]                   match;
	logic [WAYS-1:0]                   new_way;

	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		busy    = 1'b0;
		done    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				// held off while the RAM is cleared after reset
				busy = ram_clearing;
				if (start && !ram_clearing) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				busy    = 1'b1;
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_mask_q <= '1;
		end else if (tag_mask_we) begin
			tag_mask_q <= tag_mask_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lookup_s1 <= req.chip_enable && (req.write_enable || req.output_enable);
			wr_s1     <= req.chip_enable && req.write_enable;
			idx_s1    <= req.set_index[IDX_W-1:0];
			tag_s1    <= req.tag_in & tag_mask_q;
			victim_s1 <= req.victim_way;
		end
	end

	ftlu_tag_ram u_tag_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_idx   (req.set_index[IDX_W-1:0]),
		.wr       (ram_wr),
		.clearing (ram_clearing),
		.rd_tags  (rd_tags)
	);

	// commit the previous write while the current one is resolved
	always_comb begin
		ram_wr.way_we = (done && pend_valid_q) ? pend_way_q : '0;
		ram_wr.idx    = pend_idx_q;
		ram_wr.tag    = pend_tag_q;
	end

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			cmp_match[w] = (rd_tags[w] == tag_s1);
		end
		fwd = lookup_s1 && pend_valid_q && (pend_idx_q == idx_s1);
		if (fwd) begin
			match = pend_way_q;
		end else if (lookup_s1) begin
			match = cmp_match;
		end else begin
			match = '0;
		end
		hit     = fwd || (match != '0);
		new_way = hit ? match : WAY_BIT[victim_s1];

		result.hit        = hit;
		result.way_match  = match;
		result.snoop_ways = fwd ? pend_way_q : '0;
		result.evict      = wr_s1 && !hit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (done) begin
			pend_valid_q <= wr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			pend_idx_q <= idx_s1;
			pend_tag_q <= tag_s1;
			pend_way_q <= wr_s1 ? new_way : '0;
		end
	end

	a_result_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held longer than one cycle");

	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> done)
		else $error("accepted transaction gave no result");

	a_pending_has_way: assert property (@(posedge clk) disable iff (!arst_n)
		pend_valid_q |-> (pend_way_q != '0))
		else $error("pending write with no target way");

	a_snoop_is_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.snoop_ways != '0)) |->
			(result.hit && (result.way_match == result.snoop_ways)))
		else $error("forwarded result inconsistent");

	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.evict) |-> (!result.hit && (result.way_match == '0)))
		else $error("evict reported on a hit");

endmodule

// ----- dv/tb_four_way_tag_lookup_update_core.sv -----
module tb_four_way_tag_lookup_update_core;
	import ftlu_pkg::*;

	// bus cycle kinds, decoded into chip/write/output enables
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_DESELECT_WR,
		OP_NO_OE,
		OP_READ,
		OP_WRITE,
		OP_WRITE_OE
	} bus_op_t;

	typedef struct {
		req_t r;
		bit   typed;
		rsp_t rsp;
	} stim_row_t;

	localparam int                  CYCLE_LIMIT   = 200000;
	localparam int                  PHASE_LOOKUPS = 300;
	localparam int                  PHASES        = 4;
	localparam logic [TAG_BITS-1:0] MASK_ALL      = '1;
	localparam logic [TAG_BITS-1:0] MASK_NONE     = '0;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	req_t                req;
	logic                tag_mask_we;
	logic [TAG_BITS-1:0] tag_mask_wdata;
	logic                done;
	rsp_t                result;

	four_way_tag_lookup_update_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req            (req),
		.tag_mask_we    (tag_mask_we),
		.tag_mask_wdata (tag_mask_wdata),
		.done           (done),
		.result         (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog: a hung handshake ends the run as a failure
	int cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("Test completed with failures");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Predictor state: its own copy of the tag stores, the one-deep
	// pending write and the tag mask.
	// ------------------------------------------------------------------
	logic [TAG_BITS-1:0] way_tag_q [WAYS][SET_COUNT];
	logic                pend_valid_q;
	logic [TAG_BITS-1:0] pend_tag_q;
	int                  pend_idx_q;
	logic [WAYS-1:0]     pend_way_q;
	logic [TAG_BITS-1:0] mask_q;

	rsp_t expected_rsp_q [$];
	int   error_count   = 0;
	int   item_count    = 0;
	int   lookup_count  = 0;
	int   hit_count     = 0;
	int   forward_count = 0;
	int   evict_count   = 0;
	int   mask_writes   = 0;

	// One bus cycle through the tag array: lookup (forwarded or from the
	// stores), then commit of the older pending write, then register the
	// new one.
	function automatic rsp_t tag_array_response(input req_t r);
		rsp_t                rsp;
		logic [TAG_BITS-1:0] masked;
		int                  idx;
		logic                rd;
		logic                wr;

		rsp    = '0;
		masked = r.tag_in & mask_q;
		idx    = int'(r.set_index) % SET_COUNT;
		rd     = r.chip_enable & ~r.write_enable & r.output_enable;
		wr     = r.chip_enable & r.write_enable;

		if ((rd || wr) && pend_valid_q && pend_idx_q == idx) begin
			// same set as the pending write: index compare only, tags ignored
			rsp.hit        = 1'b1;
			rsp.way_match  = pend_way_q;
			rsp.snoop_ways = pend_way_q;
		end else if (rd || wr) begin
			for (int w = 0; w < WAYS; w++)
				if (way_tag_q[w][idx] == masked) begin
					rsp.way_match |= WAY_BIT[w];
					rsp.hit        = 1'b1;
				end
		end

		if (pend_valid_q)
			for (int w = 0; w < WAYS; w++)
				if (pend_way_q[w])
					way_tag_q[w][pend_idx_q] = pend_tag_q;

		pend_valid_q = wr;
		if (wr) begin
			pend_tag_q = masked;
			pend_idx_q = idx;
			if (rsp.hit) begin
				pend_way_q = rsp.way_match;
			end else begin
				pend_way_q = WAY_BIT[r.victim_way];
				rsp.evict  = 1'b1;
			end
		end else begin
			pend_way_q = '0;
		end
		return rsp;
	endfunction

	function automatic req_t make_req(input bus_op_t op, input logic [7:0] idx,
	                                  input logic [TAG_BITS-1:0] tag, input logic [1:0] victim);
		req_t r;

		r            = '0;
		r.set_index  = idx;
		r.tag_in     = tag;
		r.victim_way = victim;
		case (op)
			OP_IDLE: begin
			end
			OP_DESELECT_WR: begin
				r.write_enable  = 1'b1;
				r.output_enable = 1'b1;
			end
			OP_NO_OE: begin
				r.chip_enable = 1'b1;
			end
			OP_READ: begin
				r.chip_enable   = 1'b1;
				r.output_enable = 1'b1;
			end
			OP_WRITE: begin
				r.chip_enable  = 1'b1;
				r.write_enable = 1'b1;
			end
			OP_WRITE_OE: begin
				r.chip_enable   = 1'b1;
				r.write_enable  = 1'b1;
				r.output_enable = 1'b1;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Result checker: done is a one-cycle strobe, sampled at the edge
	// that ends its cycle. Every strobe must match the oldest expectation.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_rsp_q.size() == 0) begin
				error_count++;
				$display("%0t: result with no transaction outstanding: expected none, actual %p",
				         $time, result);
			end else begin
				want = expected_rsp_q.pop_front();
				if (result.hit !== want.hit || result.way_match !== want.way_match ||
				    result.snoop_ways !== want.snoop_ways || result.evict !== want.evict) begin
					error_count++;
					if (error_count <= 40) begin
						$display("%0t: result mismatch: expected hit=%0b way_match=%b snoop=%b evict=%0b",
						         $time, want.hit, want.way_match, want.snoop_ways, want.evict);
						$display("%0t:                  actual   hit=%0b way_match=%b snoop=%b evict=%0b",
						         $time, result.hit, result.way_match, result.snoop_ways,
						         result.evict);
					end
				end
			end
		end
	end

	// Present one transaction and hold it until start && !busy at an edge.
	// start stays high on return; the caller lowers it only for a gap.
	task automatic issue_bus_cycle(input req_t r, input bit typed, input rsp_t typed_rsp);
		rsp_t rsp;

		start <= 1'b1;
		req   <= r;
		do
			@(posedge clk);
		while (!(start === 1'b1 && busy === 1'b0));
		rsp = tag_array_response(r);
		expected_rsp_q.push_back(typed ? typed_rsp : rsp);
		item_count++;
		if (r.chip_enable && (r.write_enable || r.output_enable))
			lookup_count++;
		if (rsp.hit)
			hit_count++;
		if (rsp.snoop_ways != '0)
			forward_count++;
		if (rsp.evict)
			evict_count++;
	endtask

	task automatic pause_bus(input int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// quiesce: every transaction answered plus a little slack for the
	// compare cycle before touching the mask register
	task automatic drain_results();
		start <= 1'b0;
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_tag_mask(input logic [TAG_BITS-1:0] value);
		tag_mask_we    <= 1'b1;
		tag_mask_wdata <= value;
		@(posedge clk);
		tag_mask_we    <= 1'b0;
		mask_q          = value;
		mask_writes++;
	endtask

	// ------------------------------------------------------------------
	// Directed table. Rows with typed=1 carry a hand-derived result
	// (reset contents, extremes, forwarding); the rest use the predictor.
	// ------------------------------------------------------------------
	stim_row_t directed_rows [$];

	function automatic void add_row(input bus_op_t op, input logic [7:0] idx,
	                                input logic [TAG_BITS-1:0] tag, input logic [1:0] victim,
	                                input bit typed, input rsp_t rsp);
		stim_row_t row;

		row.r     = make_req(op, idx, tag, victim);
		row.typed = typed;
		row.rsp   = rsp;
		directed_rows.push_back(row);
	endfunction

	initial begin
		logic [TAG_BITS-1:0] tag_pool [6];
		logic [TAG_BITS-1:0] phase_mask [PHASES];
		bus_op_t             op;
		logic [7:0]          idx;
		logic [TAG_BITS-1:0] tag;
		int                  sel;
		int                  phase_lookups;
		bit                  quiet;

		// everything known from time zero
		arst_n         <= 1'b0;
		start          <= 1'b0;
		req            <= '0;
		tag_mask_we    <= 1'b0;
		tag_mask_wdata <= '0;

		for (int w = 0; w < WAYS; w++)
			for (int s = 0; s < SET_COUNT; s++)
				way_tag_q[w][s] = '0;
		pend_valid_q = 1'b0;
		pend_tag_q   = '0;
		pend_idx_q   = 0;
		pend_way_q   = '0;
		mask_q       = MASK_ALL;

		// idle cycles and a read against the cleared stores
		add_row(OP_IDLE,        8'd0,   20'h00000, 2'd0, 1, rsp_t'{1'b0, 4'h0, 4'h0, 1'b0});
		add_row(OP_READ,        8'd0,   20'h00000, 2'd0, 1, rsp_t'{1'b1, 4'hF, 4'h0, 1'b0});
		add_row(OP_NO_OE,       8'd0,   20'h00000, 2'd0, 1, rsp_t'{1'b0, 4'h0, 4'h0, 1'b0});
		add_row(OP_READ,        8'd255, 20'hFFFFF, 2'd3, 1, rsp_t'{1'b0, 4'h0, 4'h0, 1'b0});
		// write miss at the top set evicts way 3, next read forwards it
		add_row(OP_WRITE,       8'd255, 20'hFFFFF, 2'd3, 1, rsp_t'{1'b0, 4'h0, 4'h0, 1'b1});
		add_row(OP_READ,        8'd255, 20'h00000, 2'd0, 1, rsp_t'{1'b1, 4'h8, 4'h8, 1'b0});
		add_row(OP_READ,        8'd255, 20'hFFFFF, 2'd0, 0, '0);
		// write hit, then a write forwarded onto the pending way
		add_row(OP_WRITE,       8'd255, 20'hFFFFF, 2'd0, 0, '0);
		add_row(OP_WRITE_OE,    8'd255, 20'h12345, 2'd1, 0, '0);
		add_row(OP_READ,        8'd255, 20'h12345, 2'd2, 0, '0);
		add_row(OP_READ,        8'd255, 20'h12345, 2'd2, 0, '0);
		// several ways match: all four written at once
		add_row(OP_WRITE,       8'd7,   20'h00000, 2'd2, 1, rsp_t'{1'b1, 4'hF, 4'h0, 1'b0});
		add_row(OP_READ,        8'd7,   20'h00000, 2'd1, 0, '0);
		add_row(OP_DESELECT_WR, 8'd7,   20'hABCDE, 2'd3, 1, rsp_t'{1'b0, 4'h0, 4'h0, 1'b0});
		add_row(OP_READ,        8'd7,   20'hABCDE, 2'd0, 0, '0);
		add_row(OP_WRITE_OE,    8'd128, 20'hAAAAA, 2'd1, 0, '0);
		add_row(OP_READ,        8'd128, 20'h55555, 2'd0, 0, '0);
		add_row(OP_READ,        8'd128, 20'hAAAAA, 2'd0, 0, '0);
		add_row(OP_WRITE,       8'd1,   20'h80000, 2'd2, 0, '0);
		add_row(OP_WRITE,       8'd2,   20'h00001, 2'd0, 0, '0);
		add_row(OP_READ,        8'd1,   20'h80000, 2'd3, 0, '0);
		add_row(OP_READ,        8'd2,   20'h00001, 2'd3, 0, '0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue_bus_cycle(directed_rows[i].r, directed_rows[i].typed, directed_rows[i].rsp);

		// mask settings per random phase: clear, random, low nibble, all ones
		phase_mask[0] = MASK_NONE;
		phase_mask[1] = TAG_BITS'($urandom);
		phase_mask[2] = 20'h0000F;
		phase_mask[3] = MASK_ALL;

		for (int ph = 0; ph < PHASES; ph++) begin
			drain_results();
			write_tag_mask(phase_mask[ph]);
			foreach (tag_pool[i])
				tag_pool[i] = TAG_BITS'($urandom);
			phase_lookups = 0;
			quiet         = 1'b0;
			while (phase_lookups < PHASE_LOOKUPS) begin
				sel = $urandom_range(0, 99);
				if (sel < 40)      op = OP_READ;
				else if (sel < 65) op = OP_WRITE;
				else if (sel < 80) op = OP_WRITE_OE;
				else if (sel < 88) op = OP_NO_OE;
				else if (sel < 94) op = OP_IDLE;
				else               op = OP_DESELECT_WR;

				// a handful of hot sets so writes are followed by hits and forwards
				sel = $urandom_range(0, 99);
				if (sel < 60)      idx = 8'($urandom_range(0, 3));
				else if (sel < 75) idx = 8'($urandom_range(252, 255));
				else               idx = 8'($urandom);

				sel = $urandom_range(0, 99);
				if (sel < 50)      tag = tag_pool[$urandom_range(0, 5)];
				else if (sel < 65) tag = '0;
				else               tag = TAG_BITS'($urandom);

				issue_bus_cycle(make_req(op, idx, tag, 2'($urandom)), 1'b0, '0);
				if (op == OP_READ || op == OP_WRITE || op == OP_WRITE_OE)
					phase_lookups++;

				// sender gaps, none in the final phase; quiet stretches in between
				if ($urandom_range(0, 63) == 0)
					quiet = ~quiet;
				if (ph != PHASES - 1 && !quiet && $urandom_range(0, 7) == 0)
					pause_bus($urandom_range(1, 14));
			end
		end

		drain_results();

		$display("Ran %0d transactions (%0d lookups): %0d hits, %0d forwarded, %0d evictions",
		         item_count, lookup_count, hit_count, forward_count, evict_count);
		$display("Tag mask written %0d times including all-zero and all-one; %0d mismatches",
		         mask_writes, error_count);
		if (error_count == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
